// ----- src/fjot_pkg.sv -----
`default_nettype none
// ============================================================================
// fjot_pkg: shared types and constants for the flat JSON object tokenizer
// Holds the event kinds, error codes and the word passed between front and back.
// ============================================================================
package fjot_pkg;

    localparam int QueueDepth = 4;

    typedef enum logic [3:0] {
        EV_NONE    = 4'd0,
        EV_KEYCHAR = 4'd1,
        EV_KEYEND  = 4'd2,
        EV_STRCHAR = 4'd3,
        EV_STREND  = 4'd4,
        EV_INTEGER = 4'd5,
        EV_TRUE    = 4'd6,
        EV_FALSE   = 4'd7,
        EV_NULL    = 4'd8,
        EV_CLOSED  = 4'd9,
        EV_DOC_OK  = 4'd10,
        EV_ERROR   = 4'd11
    } event_kind_t;

    typedef enum logic [3:0] {
        ER_NONE      = 4'd0,
        ER_NOTOBJ    = 4'd1,
        ER_NOSTRING  = 4'd2,
        ER_NOCOLON   = 4'd3,
        ER_BADVALUE  = 4'd4,
        ER_CTRL      = 4'd5,
        ER_ESCAPE    = 4'd6,
        ER_UNTERM    = 4'd7,
        ER_NODIGIT   = 4'd8,
        ER_NONINT    = 4'd9,
        ER_RANGE     = 4'd10,
        ER_NOCOMMA   = 4'd11,
        ER_TRAILING  = 4'd12
    } error_code_t;

    typedef enum logic [3:0] {
        PH_OPEN, PH_FIRST, PH_KEY_START, PH_KEY, PH_COLON, PH_VALUE, PH_STRING,
        PH_SIGN, PH_NUMBER, PH_LITERAL, PH_AFTER, PH_TRAIL, PH_ERROR
    } phase_t;

    // Classified byte handed from the front to the back.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } word_t;

    // One emitted result, before last_of_run is attached.
    typedef struct packed {
        event_kind_t kind;
        logic [7:0]  ch;
        error_code_t err;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] s, input logic [2:0] p);
        logic [7:0] r;
        r = 8'h00;
        unique case (s)
            2'd0: begin
                unique case (p)
                    3'd0: r = "t";
                    3'd1: r = "r";
                    3'd2: r = "u";
                    3'd3: r = "e";
                    default: r = 8'h00;
                endcase
            end
            2'd1: begin
                unique case (p)
                    3'd0: r = "f";
                    3'd1: r = "a";
                    3'd2: r = "l";
                    3'd3: r = "s";
                    3'd4: r = "e";
                    default: r = 8'h00;
                endcase
            end
            2'd2: begin
                unique case (p)
                    3'd0: r = "n";
                    3'd1: r = "u";
                    3'd2: r = "l";
                    3'd3: r = "l";
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/flat_json_object_tokenizer.sv -----
`default_nettype none
// A byte's first result passes the front register, the queue and the output slot
// before it shows at m_valid. Throughput: one byte per cycle while m_ready is high,
// except a byte giving two results holds the parser while the second word drains.
// The front register, a queue of QueueDepth words and the parser stage run on their
// own handshakes. Reset (aresetn low, synchronous) empties all stages and returns
// the parser to expecting an opening brace.
// ============================================================================
// flat_json_object_tokenizer: streaming tokenizer for one flat JSON object
// The front registers each byte word, the queue decouples it from the parser,
// and the back parses and emits key/string characters, integers and status.
// ============================================================================
module flat_json_object_tokenizer
    import fjot_pkg::*;
#(
    parameter int Depth = QueueDepth
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_text_byte,
    input  wire logic          s_end_of_text,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [3:0]         m_event_kind,
    output logic [7:0]         m_char_out,
    output logic signed [63:0] m_integer_out,
    output logic [3:0]         m_error_code,
    output logic               m_last_of_run
);
    // Word from the front register into the queue.
    logic  f_valid, f_ready;
    word_t f_word;
    // Word from the queue into the parser.
    logic  q_valid, q_ready;
    word_t q_word;

    fjot_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_text_byte, .s_end_of_text,
        .q_valid(f_valid), .q_ready(f_ready), .q_word(f_word)
    );

    fjot_queue #(.Depth(Depth)) u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_word(f_word),
        .out_valid(q_valid), .out_ready(q_ready), .out_word(q_word)
    );

    fjot_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_word,
        .m_valid, .m_ready, .m_event_kind, .m_char_out, .m_integer_out,
        .m_error_code, .m_last_of_run
    );
endmodule
`default_nettype wire

// ----- src/fjot_queue.sv -----
`default_nettype none
// ============================================================================
// fjot_queue: short word queue between front and back
// A small circular buffer with valid/ready on both sides.
// ============================================================================
module fjot_queue
    import fjot_pkg::*;
#(
    parameter int Depth = QueueDepth
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire word_t in_word,
    output logic       out_valid,
    input  wire logic  out_ready,
    output word_t      out_word
);
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    word_t mem_reg [Depth];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic push, pop;

    assign in_ready  = cnt_reg != (AW+1)'(Depth);
    assign out_valid = cnt_reg != '0;
    assign out_word  = mem_reg[rd_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == AW'(Depth - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == AW'(Depth - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

// ----- src/fjot_front.sv -----
`default_nettype none
// ============================================================================
// fjot_front: input stage of the tokenizer
// Registers each accepted byte and folds a zero byte into end of text.
// ============================================================================
module fjot_front
    import fjot_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_text_byte,
    input  wire logic       s_end_of_text,
    output logic            q_valid,
    input  wire logic       q_ready,
    output word_t           q_word
);
    logic  vld_reg;
    word_t word_reg;

    assign s_ready = !vld_reg || q_ready;
    assign q_valid = vld_reg;
    assign q_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg.text_byte   <= s_text_byte;
            word_reg.end_of_text <= s_end_of_text || (s_text_byte == 8'h00);
        end
    end
endmodule
`default_nettype wire

// ----- src/fjot_back.sv -----
`default_nettype none
// ============================================================================
// fjot_back: parser and result stage
// Advances the parse state per word and delivers up to two results per word.
// ============================================================================
module fjot_back
    import fjot_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         q_valid,
    output logic              q_ready,
    input  wire word_t        q_word,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [3:0]        m_event_kind,
    output logic [7:0]        m_char_out,
    output logic signed [63:0] m_integer_out,
    output logic [3:0]        m_error_code,
    output logic              m_last_of_run
);
    phase_t      phase_reg, phase_next;
    logic        esc_reg, esc_next;
    logic [1:0]  sel_reg, sel_next;
    logic [2:0]  pos_reg, pos_next;
    logic        neg_reg, neg_next;
    logic [63:0] mag_reg, mag_next;
    logic        lz_reg, lz_next;
    logic        ovf_reg, ovf_next;
    error_code_t herr_reg, herr_next;

    // Output slots: slot 0 drives the port, slot 1 holds a second result.
    logic    v0_reg, v1_reg;
    result_t r0_reg, r1_reg;
    logic    l0_reg;
    logic [63:0] i0_reg, i1_reg;

    logic    n_cnt0, n_cnt1;
    result_t e0, e1;
    logic [63:0] ei0;
    logic [7:0] c;
    logic       fin;
    logic [63:0] value;
    logic [63:0] mag10;
    logic [64:0] sum;
    logic [3:0]  d;
    logic [2:0]  litlen;
    logic [7:0]  dec;
    logic        dec_ok;
    logic        take;

    assign c      = q_word.text_byte;
    assign fin    = q_word.end_of_text;
    assign value  = neg_reg ? (64'd0 - mag_reg) : mag_reg;
    assign d      = c[3:0];
    assign mag10  = {mag_reg[60:0], 3'b000} + {mag_reg[62:0], 1'b0};
    assign sum    = {1'b0, mag10} + 65'(d);
    assign litlen = (sel_reg == 2'd1) ? 3'd5 : 3'd4;

    // Only take a word when both slots are free after this cycle.
    assign q_ready = !v1_reg && (!v0_reg || m_ready);
    assign take    = q_valid && q_ready;

    assign m_valid       = v0_reg;
    assign m_event_kind  = r0_reg.kind;
    assign m_char_out    = r0_reg.ch;
    assign m_error_code  = r0_reg.err;
    assign m_integer_out = i0_reg;
    assign m_last_of_run = l0_reg;

    always_comb begin
        dec_ok = 1'b1;
        dec    = c;
        unique case (c)
            8'h22, 8'h5c, 8'h2f: dec = c;
            "b": dec = 8'd8;
            "f": dec = 8'd12;
            "n": dec = 8'd10;
            "r": dec = 8'd13;
            "t": dec = 8'd9;
            default: dec_ok = 1'b0;
        endcase
    end

    // Next-state logic of the parser; emits into e0/e1.
    always_comb begin
        logic key;
        logic nlimit_hit;
        phase_next = phase_reg;
        esc_next = esc_reg; sel_next = sel_reg; pos_next = pos_reg;
        neg_next = neg_reg; mag_next = mag_reg; lz_next = lz_reg;
        ovf_next = ovf_reg; herr_next = herr_reg;
        n_cnt0 = 1'b0; n_cnt1 = 1'b0;
        e0 = '{kind: EV_NONE, ch: 8'h00, err: ER_NONE};
        e1 = '{kind: EV_NONE, ch: 8'h00, err: ER_NONE};
        ei0 = 64'd0;
        key = (phase_reg == PH_KEY);
        // Overflow when the accumulated value passes the signed limit.
        nlimit_hit = (mag_reg > 64'd922337203685477580) || sum[64] ||
            (neg_reg ? (sum[63:0] > 64'h8000_0000_0000_0000)
                     : sum[63]);
        if (fin) begin
            n_cnt0 = 1'b1;
            e0.kind = EV_ERROR;
            unique case (phase_reg)
                PH_TRAIL: e0.kind = EV_DOC_OK;
                PH_ERROR: e0.err = herr_reg;
                PH_OPEN:  e0.err = ER_NOTOBJ;
                PH_FIRST, PH_KEY_START: e0.err = ER_NOSTRING;
                PH_KEY, PH_STRING: e0.err = esc_reg ? ER_ESCAPE : ER_UNTERM;
                PH_COLON: e0.err = ER_NOCOLON;
                PH_SIGN:  e0.err = ER_NODIGIT;
                PH_NUMBER: begin
                    if (!lz_reg && ovf_reg) begin
                        e0.err = ER_RANGE;
                    end else begin
                        e0.kind = EV_INTEGER;
                        ei0 = value;
                        n_cnt1 = 1'b1;
                        e1.kind = EV_ERROR;
                        e1.err = ER_NOCOMMA;
                    end
                end
                PH_AFTER: e0.err = ER_NOCOMMA;
                default: e0.err = ER_BADVALUE;
            endcase
            phase_next = PH_OPEN;
            esc_next = 1'b0; sel_next = '0; pos_next = '0; neg_next = 1'b0;
            mag_next = '0; lz_next = 1'b0; ovf_next = 1'b0; herr_next = ER_NONE;
        end else begin
            unique case (phase_reg)
                PH_OPEN: begin
                    if (!is_ws(c)) begin
                        if (c == "{") phase_next = PH_FIRST;
                        else begin phase_next = PH_ERROR; herr_next = ER_NOTOBJ; end
                    end
                end
                PH_FIRST, PH_KEY_START: begin
                    if (!is_ws(c)) begin
                        if (c == "}" && phase_reg == PH_FIRST) begin
                            n_cnt0 = 1'b1; e0.kind = EV_CLOSED; phase_next = PH_TRAIL;
                        end else if (c == 8'h22) begin
                            esc_next = 1'b0; phase_next = PH_KEY;
                        end else begin
                            phase_next = PH_ERROR; herr_next = ER_NOSTRING;
                        end
                    end
                end
                PH_KEY, PH_STRING: begin
                    if (esc_reg) begin
                        esc_next = 1'b0;
                        if (!dec_ok) begin
                            phase_next = PH_ERROR; herr_next = ER_ESCAPE;
                        end else begin
                            n_cnt0 = 1'b1; e0.ch = dec;
                            e0.kind = key ? EV_KEYCHAR : EV_STRCHAR;
                        end
                    end else if (c == 8'h22) begin
                        n_cnt0 = 1'b1;
                        e0.kind = key ? EV_KEYEND : EV_STREND;
                        phase_next = key ? PH_COLON : PH_AFTER;
                    end else if (c < 8'h20) begin
                        phase_next = PH_ERROR; herr_next = ER_CTRL;
                    end else if (c == 8'h5c) begin
                        esc_next = 1'b1;
                    end else begin
                        n_cnt0 = 1'b1; e0.ch = c;
                        e0.kind = key ? EV_KEYCHAR : EV_STRCHAR;
                    end
                end
                PH_COLON: begin
                    if (!is_ws(c)) begin
                        if (c == ":") phase_next = PH_VALUE;
                        else begin phase_next = PH_ERROR; herr_next = ER_NOCOLON; end
                    end
                end
                PH_VALUE: begin
                    if (!is_ws(c)) begin
                        if (c == 8'h22) begin
                            esc_next = 1'b0; phase_next = PH_STRING;
                        end else if (c == "-") begin
                            neg_next = 1'b1; phase_next = PH_SIGN;
                        end else if (is_digit(c)) begin
                            neg_next = 1'b0; lz_next = (c == "0");
                            mag_next = 64'(d); ovf_next = 1'b0; phase_next = PH_NUMBER;
                        end else if (c == "t" || c == "f" || c == "n") begin
                            sel_next = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
                            pos_next = 3'd1; phase_next = PH_LITERAL;
                        end else begin
                            phase_next = PH_ERROR; herr_next = ER_BADVALUE;
                        end
                    end
                end
                PH_SIGN: begin
                    if (is_digit(c)) begin
                        lz_next = (c == "0"); mag_next = 64'(d);
                        ovf_next = 1'b0; phase_next = PH_NUMBER;
                    end else begin
                        phase_next = PH_ERROR; herr_next = ER_NODIGIT;
                    end
                end
                PH_NUMBER: begin
                    if (is_digit(c) && lz_reg) begin
                        phase_next = PH_ERROR; herr_next = ER_RANGE;
                    end else if (is_digit(c)) begin
                        if (!ovf_reg) begin
                            if (nlimit_hit) ovf_next = 1'b1;
                            else mag_next = sum[63:0];
                        end
                    end else if (c == "." || c == "e" || c == "E") begin
                        phase_next = PH_ERROR; herr_next = ER_NONINT;
                    end else if (ovf_reg) begin
                        phase_next = PH_ERROR; herr_next = ER_RANGE;
                    end else begin
                        n_cnt0 = 1'b1; e0.kind = EV_INTEGER; ei0 = value;
                        phase_next = PH_AFTER;
                        if (!is_ws(c)) begin
                            if (c == "}") begin
                                n_cnt1 = 1'b1; e1.kind = EV_CLOSED; phase_next = PH_TRAIL;
                            end else if (c == ",") begin
                                phase_next = PH_KEY_START;
                            end else begin
                                phase_next = PH_ERROR; herr_next = ER_NOCOMMA;
                            end
                        end
                    end
                end
                PH_LITERAL: begin
                    if (pos_reg >= litlen || c != lit_char(sel_reg, pos_reg)) begin
                        phase_next = PH_ERROR; herr_next = ER_BADVALUE;
                    end else begin
                        pos_next = pos_reg + 3'd1;
                        if (pos_reg + 3'd1 >= litlen) begin
                            n_cnt0 = 1'b1;
                            e0.kind = (sel_reg == 2'd0) ? EV_TRUE :
                                      (sel_reg == 2'd1) ? EV_FALSE : EV_NULL;
                            phase_next = PH_AFTER;
                        end
                    end
                end
                PH_AFTER: begin
                    if (!is_ws(c)) begin
                        if (c == "}") begin
                            n_cnt0 = 1'b1; e0.kind = EV_CLOSED; phase_next = PH_TRAIL;
                        end else if (c == ",") begin
                            phase_next = PH_KEY_START;
                        end else begin
                            phase_next = PH_ERROR; herr_next = ER_NOCOMMA;
                        end
                    end
                end
                PH_TRAIL: begin
                    if (!is_ws(c)) begin
                        phase_next = PH_ERROR; herr_next = ER_TRAILING;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_OPEN;
            esc_reg <= 1'b0; sel_reg <= '0; pos_reg <= '0; neg_reg <= 1'b0;
            mag_reg <= '0; lz_reg <= 1'b0; ovf_reg <= 1'b0; herr_reg <= ER_NONE;
        end else if (take) begin
            phase_reg <= phase_next;
            esc_reg <= esc_next; sel_reg <= sel_next; pos_reg <= pos_next;
            neg_reg <= neg_next; mag_reg <= mag_next; lz_reg <= lz_next;
            ovf_reg <= ovf_next; herr_reg <= herr_next;
        end
    end

    // Output slots. Taking a word implies slot 1 is empty and slot 0 is empty or drains.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end else if (take) begin
            v0_reg <= n_cnt0;
            v1_reg <= n_cnt1;
        end else if (v0_reg && m_ready) begin
            v0_reg <= v1_reg;
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            r0_reg <= e0;
            i0_reg <= ei0;
            l0_reg <= !n_cnt1;
            r1_reg <= e1;
            i1_reg <= 64'd0;
        end else if (v0_reg && m_ready) begin
            r0_reg <= r1_reg;
            i0_reg <= i1_reg;
            l0_reg <= 1'b1;
        end
    end
endmodule
`default_nettype wire

// ----- src/fjot_checker.sv -----
`default_nettype none
// ============================================================================
// fjot_checker: port-level checks for the tokenizer
// Watches the result channel and the reset behavior.
// ============================================================================
module fjot_checker
    import fjot_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [3:0]  m_event_kind,
    input wire logic [3:0]  m_error_code,
    input wire logic [63:0] m_integer_out,
    input wire logic        m_last_of_run
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind))
        else $error("result dropped under stall");
    a_errcode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != EV_ERROR |-> m_error_code == ER_NONE)
        else $error("error code on non-error event");
    a_errlast: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind == EV_ERROR || m_event_kind == EV_DOC_OK)
        |-> m_last_of_run)
        else $error("status not last");
    a_int: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != EV_INTEGER |-> m_integer_out == 64'd0)
        else $error("integer on non-integer event");
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("valid after reset");
endmodule

bind flat_json_object_tokenizer fjot_checker u_fjot_checker (
    .aclk, .aresetn, .m_valid, .m_ready, .m_event_kind, .m_error_code,
    .m_integer_out, .m_last_of_run
);
`default_nettype wire

// ----- dv/testbench.sv -----
// ============================================================================
// Testbench for the flat JSON object tokenizer
// Feeds texts one byte per word, predicts the events of every accepted word
// and compares each received word with the oldest expected event.
// ============================================================================
module testbench;
    import fjot_pkg::*;

    // One input word as the driver presents it.
    typedef struct {
        logic [7:0] text_byte;
        logic       end_of_text;
    } byte_word_t;

    // One expected result word.
    typedef struct {
        event_kind_t       kind;
        logic [7:0]        ch;
        logic signed [63:0] value;
        error_code_t       err;
        logic              last;
    } event_word_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_text_byte;
    logic               s_end_of_text;
    logic               m_valid;
    logic               m_ready;
    logic [3:0]         m_event_kind;
    logic [7:0]         m_char_out;
    logic signed [63:0] m_integer_out;
    logic [3:0]         m_error_code;
    logic               m_last_of_run;

    flat_json_object_tokenizer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_text_byte(s_text_byte), .s_end_of_text(s_end_of_text),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_event_kind(m_event_kind), .m_char_out(m_char_out),
        .m_integer_out(m_integer_out), .m_error_code(m_error_code),
        .m_last_of_run(m_last_of_run)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    byte_word_t  pending_bytes[$];
    event_word_t expected_events[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          stimulus_done = 0;
    bit          quiet_tail = 0;   // no idling on either side at the end
    bit          hold_sink = 0;    // long receiver hold-off
    bit          hold_source = 0;  // sender pause until drained

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the parser.
    // ------------------------------------------------------------------
    phase_t      pr_phase;
    logic        pr_escape;
    logic [1:0]  pr_lit_sel;
    logic [2:0]  pr_lit_pos;
    logic        pr_negative;
    logic [63:0] pr_magnitude;
    logic        pr_lead_zero;
    logic        pr_overflow;
    error_code_t pr_held;
    event_word_t step_events[$];

    function automatic void parser_clear();
        pr_phase = PH_OPEN; pr_escape = 0; pr_lit_sel = 0; pr_lit_pos = 0;
        pr_negative = 0; pr_magnitude = 0; pr_lead_zero = 0; pr_overflow = 0;
        pr_held = ER_NONE;
    endfunction

    function automatic void add_event(event_kind_t k, logic [7:0] c,
                                      logic [63:0] v, error_code_t e);
        event_word_t w;
        w.kind = k; w.ch = c; w.value = v; w.err = e; w.last = 0;
        step_events.insert(step_events.size(), w);
    endfunction

    function automatic void parse_fail(error_code_t e);
        pr_held = e;
        pr_phase = PH_ERROR;
    endfunction

    function automatic bit blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit numeral(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [63:0] signed_value();
        return pr_negative ? 64'd0 - pr_magnitude : pr_magnitude;
    endfunction

    function automatic void text_char(logic [7:0] c, bit is_key);
        logic [7:0] d;
        bit         ok;
        if (pr_escape) begin
            pr_escape = 0;
            ok = 1;
            case (c)
                "\"", "\\", "/": d = c;
                "b": d = 8'd8;
                "f": d = 8'd12;
                "n": d = 8'd10;
                "r": d = 8'd13;
                "t": d = 8'd9;
                default: begin
                    ok = 0;
                    d = 0;
                end
            endcase
            if (!ok) parse_fail(ER_ESCAPE);
            else add_event(is_key ? EV_KEYCHAR : EV_STRCHAR, d, 0, ER_NONE);
        end else if (c == "\"") begin
            add_event(is_key ? EV_KEYEND : EV_STREND, 0, 0, ER_NONE);
            pr_phase = is_key ? PH_COLON : PH_AFTER;
        end else if (c < 8'h20) begin
            parse_fail(ER_CTRL);
        end else if (c == "\\") begin
            pr_escape = 1;
        end else begin
            add_event(is_key ? EV_KEYCHAR : EV_STRCHAR, c, 0, ER_NONE);
        end
    endfunction

    function automatic void after_value(logic [7:0] c);
        if (blank(c)) return;
        if (c == "}") begin
            add_event(EV_CLOSED, 0, 0, ER_NONE);
            pr_phase = PH_TRAIL;
        end else if (c == ",") pr_phase = PH_KEY_START;
        else parse_fail(ER_NOCOMMA);
    endfunction

    function automatic void first_digit(logic [7:0] c);
        pr_lead_zero = (c == "0");
        pr_magnitude = 64'(c - "0");
        pr_overflow = 0;
        pr_phase = PH_NUMBER;
    endfunction

    function automatic void number_char(logic [7:0] c);
        logic [63:0] d, limit;
        if (pr_lead_zero) begin
            if (numeral(c)) begin
                parse_fail(ER_RANGE);
                return;
            end
        end else if (numeral(c)) begin
            d = 64'(c - "0");
            limit = pr_negative ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            if (!pr_overflow) begin
                if (pr_magnitude > (limit - d) / 10) pr_overflow = 1;
                else pr_magnitude = pr_magnitude * 10 + d;
            end
            return;
        end
        if (c == "." || c == "e" || c == "E") begin
            parse_fail(ER_NONINT);
            return;
        end
        if (pr_overflow) begin
            parse_fail(ER_RANGE);
            return;
        end
        add_event(EV_INTEGER, 0, signed_value(), ER_NONE);
        pr_phase = PH_AFTER;
        after_value(c);
    endfunction

    function automatic void literal_char(logic [7:0] c);
        string       word;
        logic [2:0]  len;
        word = (pr_lit_sel == 0) ? "true" : (pr_lit_sel == 1) ? "false" : "null";
        len = 3'(word.len());
        if (c != word[pr_lit_pos]) begin
            parse_fail(ER_BADVALUE);
            return;
        end
        pr_lit_pos = pr_lit_pos + 1;
        if (pr_lit_pos >= len) begin
            add_event(event_kind_t'(EV_TRUE + pr_lit_sel), 0, 0, ER_NONE);
            pr_phase = PH_AFTER;
        end
    endfunction

    function automatic void text_end();
        case (pr_phase)
            PH_TRAIL: add_event(EV_DOC_OK, 0, 0, ER_NONE);
            PH_ERROR: add_event(EV_ERROR, 0, 0, pr_held);
            PH_OPEN: add_event(EV_ERROR, 0, 0, ER_NOTOBJ);
            PH_FIRST, PH_KEY_START: add_event(EV_ERROR, 0, 0, ER_NOSTRING);
            PH_KEY, PH_STRING:
                add_event(EV_ERROR, 0, 0, pr_escape ? ER_ESCAPE : ER_UNTERM);
            PH_COLON: add_event(EV_ERROR, 0, 0, ER_NOCOLON);
            PH_SIGN: add_event(EV_ERROR, 0, 0, ER_NODIGIT);
            PH_NUMBER: begin
                if (!pr_lead_zero && pr_overflow) add_event(EV_ERROR, 0, 0, ER_RANGE);
                else begin
                    add_event(EV_INTEGER, 0, signed_value(), ER_NONE);
                    add_event(EV_ERROR, 0, 0, ER_NOCOMMA);
                end
            end
            PH_AFTER: add_event(EV_ERROR, 0, 0, ER_NOCOMMA);
            default: add_event(EV_ERROR, 0, 0, ER_BADVALUE);
        endcase
        parser_clear();
    endfunction

    // Predicts the events of one accepted word and queues them.
    function automatic void tokenize_word(byte_word_t w);
        logic [7:0] c;
        c = w.text_byte;
        step_events.delete();
        if (w.end_of_text || c == 0) text_end();
        else begin
            case (pr_phase)
                PH_OPEN: begin
                    if (!blank(c)) begin
                        if (c == "{") pr_phase = PH_FIRST;
                        else parse_fail(ER_NOTOBJ);
                    end
                end
                PH_FIRST, PH_KEY_START: begin
                    if (!blank(c)) begin
                        if (c == "}" && pr_phase == PH_FIRST) begin
                            add_event(EV_CLOSED, 0, 0, ER_NONE);
                            pr_phase = PH_TRAIL;
                        end else if (c == "\"") begin
                            pr_escape = 0;
                            pr_phase = PH_KEY;
                        end else parse_fail(ER_NOSTRING);
                    end
                end
                PH_KEY: text_char(c, 1);
                PH_COLON: begin
                    if (!blank(c)) begin
                        if (c == ":") pr_phase = PH_VALUE;
                        else parse_fail(ER_NOCOLON);
                    end
                end
                PH_VALUE: begin
                    if (!blank(c)) begin
                        if (c == "\"") begin
                            pr_escape = 0;
                            pr_phase = PH_STRING;
                        end else if (c == "-") begin
                            pr_negative = 1;
                            pr_phase = PH_SIGN;
                        end else if (numeral(c)) begin
                            pr_negative = 0;
                            first_digit(c);
                        end else if (c == "t" || c == "f" || c == "n") begin
                            pr_lit_sel = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
                            pr_lit_pos = 1;
                            pr_phase = PH_LITERAL;
                        end else parse_fail(ER_BADVALUE);
                    end
                end
                PH_STRING: text_char(c, 0);
                PH_SIGN: begin
                    if (numeral(c)) first_digit(c);
                    else parse_fail(ER_NODIGIT);
                end
                PH_NUMBER: number_char(c);
                PH_LITERAL: literal_char(c);
                PH_AFTER: after_value(c);
                PH_TRAIL: begin
                    if (!blank(c)) parse_fail(ER_TRAILING);
                end
                default: ;
            endcase
        end
        if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1;
        foreach (step_events[i])
            expected_events.insert(expected_events.size(), step_events[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------
    function automatic void push_byte(logic [7:0] c, logic e = 0);
        byte_word_t w;
        w.text_byte = c; w.end_of_text = e;
        pending_bytes.insert(pending_bytes.size(), w);
    endfunction

    function automatic void push_text(string s);
        foreach (s[i]) push_byte(s[i]);
    endfunction

    function automatic void push_end();
        // Both forms of end of text: the flag with a random byte, or a zero byte.
        if ($urandom_range(1, 0)) push_byte(8'($urandom), 1);
        else push_byte(8'h00, 0);
    endfunction

    function automatic string random_blank();
        string s;
        s = "";
        repeat ($urandom_range(2, 0) == 0 ? $urandom_range(2, 1) : 0)
            s = {s, string'(byte'($urandom_range(1, 0) ? 8'h20 : $urandom_range(13, 9)))};
        return s;
    endfunction

    function automatic string random_chars(bit allow_escape);
        string s;
        byte   c;
        s = "";
        repeat ($urandom_range(4, 0)) begin
            if (allow_escape && $urandom_range(5, 0) == 0) begin
                case ($urandom_range(7, 0))
                    0: s = {s, "\\\""};
                    1: s = {s, "\\\\"};
                    2: s = {s, "\\/"};
                    3: s = {s, "\\b"};
                    4: s = {s, "\\f"};
                    5: s = {s, "\\n"};
                    6: s = {s, "\\r"};
                    default: s = {s, "\\t"};
                endcase
            end else begin
                // Printable or high bytes, never a quote or a backslash.
                do c = byte'($urandom_range(255, 32)); while (c == "\"" || c == "\\");
                s = {s, string'(c)};
            end
        end
        return s;
    endfunction

    function automatic string random_number();
        string s;
        s = $urandom_range(1, 0) ? "-" : "";
        case ($urandom_range(5, 0))
            0: s = {s, "0"};
            1: s = {s, $sformatf("%0d", $urandom_range(9, 1)),
                    $sformatf("%0d%0d", $urandom, $urandom)};  // usually too large
            2: s = {s, "9223372036854775807"};
            3: s = {s, "9223372036854775808"};
            default: s = {s, $sformatf("%0d", $urandom_range(100000, 1))};
        endcase
        return s;
    endfunction

    function automatic string random_value();
        case ($urandom_range(4, 0))
            0: return {"\"", random_chars(1), "\""};
            1: return random_number();
            2: return "true";
            3: return "false";
            default: return "null";
        endcase
    endfunction

    // A well-formed object with random content.
    function automatic string random_object();
        string s;
        int    n;
        n = $urandom_range(3, 0);
        s = {random_blank(), "{", random_blank()};
        for (int i = 0; i < n; i++) begin
            if (i > 0) s = {s, ",", random_blank()};
            s = {s, "\"", random_chars(1), "\"", random_blank(), ":", random_blank(),
                 random_value(), random_blank()};
        end
        return {s, "}", random_blank()};
    endfunction

    function automatic void push_random_text();
        string s;
        int    cut;
        s = random_object();
        case ($urandom_range(9, 0))
            0: begin
                // Truncated text: end falls anywhere inside.
                cut = $urandom_range(s.len() - 1, 0);
                s = s.substr(0, cut - 1);
                if (cut == 0) s = "";
            end
            1: begin
                // One byte replaced by a random one.
                cut = $urandom_range(s.len() - 1, 0);
                s[cut] = byte'($urandom_range(255, 1));
            end
            2: begin
                // Pure noise.
                s = "";
                repeat ($urandom_range(6, 1)) s = {s, string'(byte'($urandom_range(255, 1)))};
            end
            default: ;
        endcase
        push_text(s);
        push_end();
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers pending words, with random idle bursts.
    // ------------------------------------------------------------------
    int src_idle = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
            s_text_byte <= 0;
            s_end_of_text <= 0;
        end else begin
            if (s_valid && s_ready) begin
                tokenize_word(pending_bytes.pop_front());
            end
            if (s_valid && !s_ready) begin
                // Hold the word until it is taken.
            end else if (src_idle > 0) begin
                src_idle <= src_idle - 1;
                s_valid <= 0;
            end else if (pending_bytes.size() > 0 && !hold_source) begin
                s_valid <= 1;
                s_text_byte <= pending_bytes[0].text_byte;
                s_end_of_text <= pending_bytes[0].end_of_text;
                if (!quiet_tail && $urandom_range(15, 0) == 0)
                    src_idle <= $urandom_range(18, 1);
            end else begin
                s_valid <= 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure and comparison with the oldest expectation.
    // ------------------------------------------------------------------
    int sink_idle = 0;
    always @(posedge aclk) begin
        event_word_t e;
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected word kind=%0d", $time, m_event_kind);
                    error_count++;
                end else begin
                    e = expected_events.pop_front();
                    if (m_event_kind !== e.kind || m_char_out !== e.ch ||
                        m_integer_out !== e.value || m_error_code !== e.err ||
                        m_last_of_run !== e.last) begin
                        $display("%0t: mismatch expected kind=%0d ch=%h int=%0d err=%0d last=%0b",
                                 $time, e.kind, e.ch, e.value, e.err, e.last);
                        $display("%0t:          actual kind=%0d ch=%h int=%0d err=%0d last=%0b",
                                 $time, m_event_kind, m_char_out, m_integer_out,
                                 m_error_code, m_last_of_run);
                        error_count++;
                    end
                end
            end
            if (hold_sink) m_ready <= 0;
            else if (sink_idle > 0) begin
                sink_idle <= sink_idle - 1;
                m_ready <= 0;
            end else begin
                m_ready <= 1;
                if (!quiet_tail && $urandom_range(15, 0) == 0)
                    sink_idle <= $urandom_range(18, 1);
            end
        end
    end

    // The run is bounded; this fires only if the design hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        s_valid = 0;
        s_text_byte = 0;
        s_end_of_text = 0;
        m_ready = 0;
        aresetn = 0;
        parser_clear();
        repeat (3) @(posedge aclk);
        aresetn <= 1;

        // Directed texts: each special case, every event kind and each error kind but ER_UNTERM.
        push_text("{\"a\":\"x\\n\",\"b\":-12,\"c\":true,\"d\":false,\"e\":null}");
        push_end();
        push_text(" {}\t"); push_end();                 // empty object
        push_text("{\"k\":0}"); push_end();             // lone zero
        push_text("{\"k\":01}"); push_end();            // leading zero then digit
        push_text("{\"k\":1.5}"); push_end();           // fraction
        push_text("{\"k\":2e3}"); push_end();           // exponent
        push_text("{\"k\":-9223372036854775808}"); push_end();
        push_text("{\"k\":9223372036854775808}"); push_end();   // overflow
        push_text("{\"k\":18446744073709551616"); push_end();   // overflow at end
        push_text("{\"k\":-42"); push_end();            // end inside a number
        push_text("{\"k\":tru}"); push_end();           // literal mismatch
        push_text("{\"k\":\"a\\"); push_end();          // escape at end
        push_text("{\"k\":\"a\\q\"}"); push_end();      // bad escape
        push_text("{\"k\x01\"}"); push_end();           // control byte
        push_text("x"); push_end();
        push_end();                                      // end before the brace
        push_text("{1"); push_end();
        push_text("{\"k\"1"); push_end();
        push_text("{\"k\":-x"); push_end();
        push_text("{\"k\":}"); push_end();
        push_text("{\"k\":1 2"); push_end();
        push_text("{} x"); push_end();
        push_text("{\"k\""); push_end();
        push_text("{\"\xff\":\"\x7f\"}"); push_end();

        // Long receiver hold-off while the sender keeps offering words.
        hold_sink = 1;
        repeat (200) @(posedge aclk);
        hold_sink = 0;

        while (pending_bytes.size() < 1500) push_random_text();

        // Sender pause until every expected result has come.
        wait (pending_bytes.size() == 0);
        hold_source = 1;
        wait (expected_events.size() == 0);
        repeat (10) @(posedge aclk);
        hold_source = 0;

        while (pending_bytes.size() < 500) push_random_text();
        wait (pending_bytes.size() < 150);
        quiet_tail = 1;
        wait (pending_bytes.size() == 0 && !s_valid);
        wait (expected_events.size() == 0);
        repeat (20) @(posedge aclk);

        if (error_count == 0 && expected_events.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
